// ----- design/dct3_pkg.sv -----
package dct3_pkg;

	localparam int SampleBits = 12;
	localparam int CosFracBits = 14;
	localparam int Side = 8;
	localparam int Area = 64;
	localparam int AccBits = 44;
	localparam int BasisBits = 16;

	typedef logic signed [BasisBits-1:0] basis_t;

	// orthonormal dct-ii basis, 14 fractional bits, indexed [k][n]
	function automatic basis_t basis(input logic [2:0] k, input logic [2:0] n);
		basis_t b;
		unique case ({k, n})
			6'o00, 6'o01, 6'o02, 6'o03, 6'o04, 6'o05, 6'o06, 6'o07: b = 16'sd5793;
			6'o10: b = 16'sd8035; 6'o11: b = 16'sd6811; 6'o12: b = 16'sd4551;
			6'o13: b = 16'sd1598; 6'o14: b = -16'sd1598; 6'o15: b = -16'sd4551;
			6'o16: b = -16'sd6811; 6'o17: b = -16'sd8035;
			6'o20: b = 16'sd7568; 6'o21: b = 16'sd3135; 6'o22: b = -16'sd3135;
			6'o23: b = -16'sd7568; 6'o24: b = -16'sd7568; 6'o25: b = -16'sd3135;
			6'o26: b = 16'sd3135; 6'o27: b = 16'sd7568;
			6'o30: b = 16'sd6811; 6'o31: b = -16'sd1598; 6'o32: b = -16'sd8035;
			6'o33: b = -16'sd4551; 6'o34: b = 16'sd4551; 6'o35: b = 16'sd8035;
			6'o36: b = 16'sd1598; 6'o37: b = -16'sd6811;
			6'o40: b = 16'sd5793; 6'o41: b = -16'sd5793; 6'o42: b = -16'sd5793;
			6'o43: b = 16'sd5793; 6'o44: b = 16'sd5793; 6'o45: b = -16'sd5793;
			6'o46: b = -16'sd5793; 6'o47: b = 16'sd5793;
			6'o50: b = 16'sd4551; 6'o51: b = -16'sd8035; 6'o52: b = 16'sd1598;
			6'o53: b = 16'sd6811; 6'o54: b = -16'sd6811; 6'o55: b = -16'sd1598;
			6'o56: b = 16'sd8035; 6'o57: b = -16'sd4551;
			6'o60: b = 16'sd3135; 6'o61: b = -16'sd7568; 6'o62: b = 16'sd7568;
			6'o63: b = -16'sd3135; 6'o64: b = -16'sd3135; 6'o65: b = 16'sd7568;
			6'o66: b = -16'sd7568; 6'o67: b = 16'sd3135;
			6'o70: b = 16'sd1598; 6'o71: b = -16'sd4551; 6'o72: b = 16'sd6811;
			6'o73: b = -16'sd8035; 6'o74: b = 16'sd8035; 6'o75: b = -16'sd6811;
			6'o76: b = 16'sd4551; 6'o77: b = -16'sd1598;
			default: b = '0;
		endcase
		return b;
	endfunction

endpackage

// ----- design/dct3_mac.sv -----
// bit-serial multiply-accumulate: one weight bit per cycle while step is high, lsb first
module dct3_mac (
	input  logic clk,
	input  logic arst_n,
	input  logic clear,
	input  logic step,
	input  logic wbit,
	input  logic wsign,
	input  logic signed [dct3_pkg::AccBits-1:0] operand,
	output logic signed [dct3_pkg::AccBits-1:0] acc
);

	logic signed [dct3_pkg::AccBits-1:0] acc_q;
	logic signed [dct3_pkg::AccBits-1:0] shifted_q;
	logic signed [dct3_pkg::AccBits-1:0] addend;

	// sign bit of the weight has negative place value
	always_comb begin
		addend = '0;
		if (wbit) begin
			addend = wsign ? -shifted_q : shifted_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			shifted_q <= '0;
		end else if (clear) begin
			shifted_q <= operand;
		end else if (step) begin
			acc_q <= acc_q + addend;
			shifted_q <= shifted_q <<< 1;
		end else begin
			shifted_q <= operand;
		end
	end

	assign acc = acc_q;

endmodule

// ----- design/dct_8x8_three_channel.sv -----
// Three-channel 8x8 2-D DCT. Load 64 words (start high, busy low), raster
// order, each a Y/Cb/Cr triple. On the 64th word busy rises and the block runs
// the row pass then the column pass for all three channels at once, with
// bit-serial multiply-accumulate units that consume one of the 16 basis bits
// per cycle: each product term steps through operand address, operand load
// and the 16 bits, and each output value sums 8 terms; busy stays high
// through both passes and the output phase. The 64 results come out one per
// cycle on done, the last in the same cycle as busy falls, marked by
// block_last; the receiver cannot stall them. direction (0 forward, 1
// inverse) is sampled when the 64th word is taken.
module dct_8x8_three_channel (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic cfg_we,
	input  logic cfg_wdata,
	input  logic signed [11:0] sample_y,
	input  logic signed [11:0] sample_cb,
	input  logic signed [11:0] sample_cr,
	output logic done,
	output logic signed [11:0] out_y,
	output logic signed [11:0] out_cb,
	output logic signed [11:0] out_cr,
	output logic block_last
);

	localparam int AB = dct3_pkg::AccBits;

	typedef enum logic [1:0] {LOAD, ROWS, COLS, EMIT} state_t;

	state_t state_q;
	logic direction_q;
	logic dir_q;
	logic [5:0] load_count_q;

	// pixel store and intermediate store, one per channel
	logic signed [11:0] store_q [3][64];
	logic signed [AB-1:0] tmp_q [3][64];
	logic signed [11:0] res_q [3][64];

	// registered read ports of the two stores
	logic signed [11:0] pix_rd_q [3];
	logic signed [AB-1:0] tmp_rd_q [3];

	logic [2:0] a_q, c_q, b_q;   // output row, output col, term index
	logic [4:0] bit_q;           // 0 addresses operand, 1 loads it, 2..17 weight bits
	logic [5:0] emit_q;

	logic [2:0] wk, wn;
	dct3_pkg::basis_t w;
	logic wbit, wsign, clear, step;
	logic signed [AB-1:0] operand [3];
	logic signed [AB-1:0] acc [3];
	logic [5:0] rd_idx, wr_idx;

	// row pass: tmp[a][j] = sum_b W(a,b) x[b][j], here j = c_q
	// col pass: y[a][c] = sum_j W(c,j) tmp[a][j]
	always_comb begin
		if (state_q == ROWS) begin
			wk = a_q;
			wn = b_q;
			rd_idx = {b_q, c_q};
		end else begin
			wk = c_q;
			wn = b_q;
			rd_idx = {a_q, b_q};
		end
		w = dir_q ? dct3_pkg::basis(wn, wk) : dct3_pkg::basis(wk, wn);
		wbit = (bit_q >= 5'd2) ? w[4'(bit_q - 5'd2)] : 1'b0;
		wsign = (bit_q == 5'd17);
		clear = (bit_q == 5'd0) && (b_q == 3'd0);
		step = (state_q == ROWS || state_q == COLS) && (bit_q >= 5'd2);
		wr_idx = {a_q, c_q};
		for (int ch = 0; ch < 3; ch++) begin
			operand[ch] = (state_q == ROWS) ? AB'(pix_rd_q[ch]) : tmp_rd_q[ch];
		end
	end

	// start of each output sum: remember where the accumulator stands
	logic mac_clr;
	assign mac_clr = clear && (state_q == ROWS || state_q == COLS);

	logic signed [AB-1:0] acc_fix [3];
	logic signed [AB-1:0] prev_q [3];

	for (genvar ch = 0; ch < 3; ch++) begin : g_mac
		dct3_mac u_mac (
			.clk(clk),
			.arst_n(arst_n),
			.clear(1'b0),
			.step(step),
			.wbit(wbit),
			.wsign(wsign),
			.operand(operand[ch]),
			.acc(acc[ch])
		);
		// accumulator runs free; each output is the difference from its start
		assign acc_fix[ch] = acc[ch] - prev_q[ch];
	end

	// round to nearest, ties away, 28 fractional bits, saturate
	function automatic logic signed [11:0] finish(input logic signed [AB-1:0] v);
		logic neg;
		logic [AB-1:0] mag, r;
		neg = v[AB-1];
		mag = neg ? AB'(-v) : AB'(v);
		r = (mag + (AB'(1) << 27)) >> 28;
		if (r > AB'(2047)) begin
			return neg ? -12'sd2048 : 12'sd2047;
		end
		return neg ? -12'(r) : 12'(r);
	endfunction

	logic last_bit;
	assign last_bit = (bit_q == 5'd17);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LOAD;
			direction_q <= 1'b0;
			dir_q <= 1'b0;
			load_count_q <= '0;
			a_q <= '0;
			c_q <= '0;
			b_q <= '0;
			bit_q <= '0;
			emit_q <= '0;
			done <= 1'b0;
			block_last <= 1'b0;
			for (int ch = 0; ch < 3; ch++) prev_q[ch] <= '0;
		end else begin
			if (cfg_we) direction_q <= cfg_wdata;
			done <= 1'b0;
			block_last <= 1'b0;
			if (mac_clr) begin
				for (int ch = 0; ch < 3; ch++) prev_q[ch] <= acc[ch];
			end
			unique case (state_q)
				LOAD: begin
					if (start) begin
						for (int ch = 0; ch < 3; ch++) begin
						end
						load_count_q <= load_count_q + 6'd1;
						if (load_count_q == 6'd63) begin
							state_q <= ROWS;
							dir_q <= cfg_we ? cfg_wdata : direction_q;
						end
					end
				end
				ROWS, COLS: begin
					if (last_bit) begin
						bit_q <= '0;
						b_q <= b_q + 3'd1;
						if (b_q == 3'd7) begin
							c_q <= c_q + 3'd1;
							if (c_q == 3'd7) begin
								a_q <= a_q + 3'd1;
								if (a_q == 3'd7) begin
									state_q <= (state_q == ROWS) ? COLS : EMIT;
								end
							end
						end
					end else begin
						bit_q <= bit_q + 5'd1;
					end
				end
				EMIT: begin
					done <= 1'b1;
					block_last <= (emit_q == 6'd63);
					emit_q <= emit_q + 6'd1;
					if (emit_q == 6'd63) state_q <= LOAD;
				end
				default: state_q <= LOAD;
			endcase
		end
	end

	// result of one term sum appears the cycle after its last bit
	logic fin_s1;
	logic fin_rows_s1;
	logic [5:0] fin_idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_s1 <= 1'b0;
			fin_rows_s1 <= 1'b0;
			fin_idx_s1 <= '0;
		end else begin
			fin_s1 <= (state_q == ROWS || state_q == COLS) && last_bit && (b_q == 3'd7);
			fin_rows_s1 <= (state_q == ROWS);
			fin_idx_s1 <= wr_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == LOAD && start) begin
			store_q[0][load_count_q] <= sample_y;
			store_q[1][load_count_q] <= sample_cb;
			store_q[2][load_count_q] <= sample_cr;
		end
		for (int ch = 0; ch < 3; ch++) begin
			pix_rd_q[ch] <= store_q[ch][rd_idx];
			tmp_rd_q[ch] <= tmp_q[ch][rd_idx];
		end
		if (fin_s1) begin
			for (int ch = 0; ch < 3; ch++) begin
				if (fin_rows_s1) tmp_q[ch][fin_idx_s1] <= acc_fix[ch];
				else res_q[ch][fin_idx_s1] <= finish(acc_fix[ch]);
			end
		end
		if (state_q == EMIT) begin
			out_y <= res_q[0][emit_q];
			out_cb <= res_q[1][emit_q];
			out_cr <= res_q[2][emit_q];
		end
	end

	assign busy = (state_q != LOAD);

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		block_last |-> done) else $error("block_last without done");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy || $past(state_q) == EMIT) else $error("done outside emit");
	a_load_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> load_count_q == 6'd0) else $error("load count not wrapped");

endmodule

// ----- bench/dct_8x8_three_channel_tb.sv -----
module dct_8x8_three_channel_tb;

	localparam int SampleBits = dct3_pkg::SampleBits;
	localparam int CosFracBits = dct3_pkg::CosFracBits;
	localparam int Side = dct3_pkg::Side;
	localparam int Area = dct3_pkg::Area;

	// direction register codes
	localparam bit DIR_FORWARD = 1'b0;
	localparam bit DIR_INVERSE = 1'b1;

	// generous bound: seven blocks plus idling, many times over
	localparam int CycleLimit = 2000000;
	localparam longint unsigned PiQ30 = 64'd3373259426;

	// how a block of 64 words is filled
	typedef enum {
		FILL_CONST,
		FILL_CHECKER,
		FILL_IMPULSE,
		FILL_RANDOM,
		FILL_SMALL
	} fill_e;

	// one row of the directed table: a whole block
	typedef struct {
		bit dir;
		fill_e fill;
		int y;
		int cb;
		int cr;
		bit dc_known;   // dc term can be read off at a glance
		int dc_y;
		int dc_cb;
		int dc_cr;
	} block_row_t;

	typedef struct {
		logic signed [SampleBits-1:0] y;
		logic signed [SampleBits-1:0] cb;
		logic signed [SampleBits-1:0] cr;
		logic last;
	} coef_word_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic cfg_we;
	logic cfg_wdata;
	logic signed [SampleBits-1:0] sample_y;
	logic signed [SampleBits-1:0] sample_cb;
	logic signed [SampleBits-1:0] sample_cr;
	logic done;
	logic signed [SampleBits-1:0] out_y;
	logic signed [SampleBits-1:0] out_cb;
	logic signed [SampleBits-1:0] out_cr;
	logic block_last;

	dct_8x8_three_channel u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.sample_y(sample_y),
		.sample_cb(sample_cb),
		.sample_cr(sample_cr),
		.done(done),
		.out_y(out_y),
		.out_cb(out_cb),
		.out_cr(out_cr),
		.block_last(block_last)
	);

	// predictor state: basis table, direction, the block being loaded
	longint cos_table [Side][Side];
	bit dir_now;
	int loaded [3][Area];
	coef_word_t coef_queue [$];
	int err_count;
	int cycle_count;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// runaway guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("dct_8x8_three_channel_tb: FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d, want %0d (%0d words still due)",
			what, got, want, coef_queue.size());
		err_count++;
	endtask

	// bit-exact integer square root
	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// cos(b*pi/16) in q30 for 0 <= b <= 8, taylor series
	function automatic longint quarter_cos(input int unsigned b);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint sum;
		x = (longint'(b) * PiQ30 + Side) / (2 * Side);
		x2 = (x * x) >> 30;
		term = 64'd1 << 30;
		sum = longint'(term);
		for (int i = 1; i <= 12; i++) begin
			term = ((term * x2) >> 30) / longint'((2 * i - 1) * (2 * i));
			if (i % 2) sum -= longint'(term);
			else sum += longint'(term);
		end
		return sum;
	endfunction

	function automatic longint angle_q30(input int unsigned m);
		int unsigned r;
		int unsigned q;
		int unsigned a;
		r = m % (4 * Side);
		q = r / Side;
		a = r % Side;
		case (q)
			0: return quarter_cos(a);
			1: return -quarter_cos(Side - a);
			2: return -quarter_cos(a);
			default: return quarter_cos(Side - a);
		endcase
	endfunction

	// round to nearest, ties away from zero
	function automatic longint round_away(input longint v, input int sh);
		longint mag;
		mag = (v < 0) ? -v : v;
		mag = (mag + (longint'(1) << (sh - 1))) >>> sh;
		return (v < 0) ? -mag : mag;
	endfunction

	function automatic longint weight(input int a, input int b);
		return dir_now ? cos_table[b][a] : cos_table[a][b];
	endfunction

	// separable 2-d transform of the loaded block, queues 64 expected words
	task automatic predict_block(input block_row_t row);
		longint colpass [Area];
		longint acc;
		longint r;
		coef_word_t w [Area];
		for (int ch = 0; ch < 3; ch++) begin
			for (int a = 0; a < Side; a++)
				for (int j = 0; j < Side; j++) begin
					acc = 0;
					for (int b = 0; b < Side; b++)
						acc += weight(a, b) * longint'(loaded[ch][b * Side + j]);
					colpass[a * Side + j] = acc;
				end
			for (int a = 0; a < Side; a++)
				for (int c = 0; c < Side; c++) begin
					acc = 0;
					for (int j = 0; j < Side; j++)
						acc += weight(c, j) * colpass[a * Side + j];
					r = round_away(acc, 2 * CosFracBits);
					if (r > 2047) r = 2047;
					if (r < -2048) r = -2048;
					case (ch)
						0: w[a * Side + c].y = r[SampleBits-1:0];
						1: w[a * Side + c].cb = r[SampleBits-1:0];
						default: w[a * Side + c].cr = r[SampleBits-1:0];
					endcase
				end
		end
		// where the dc term is obvious, check the block against it directly
		if (row.dc_known) begin
			w[0].y = row.dc_y[SampleBits-1:0];
			w[0].cb = row.dc_cb[SampleBits-1:0];
			w[0].cr = row.dc_cr[SampleBits-1:0];
		end
		for (int i = 0; i < Area; i++) begin
			w[i].last = (i == Area - 1);
			coef_queue = {coef_queue, w[i]};
		end
	endtask

	function automatic int fill_value(input fill_e f, input int base, input int idx);
		case (f)
			FILL_CONST: return base;
			FILL_CHECKER: return (((idx / Side) + (idx % Side)) % 2) ? -base - 1 : base;
			FILL_IMPULSE: return (idx == 0) ? base : 0;
			FILL_RANDOM: return $signed(12'($urandom));
			default: return $urandom_range(0, 128) - 64;
		endcase
	endfunction

	// block is idle: nothing due, not busy, then a spare margin
	task automatic write_direction(input bit d);
		while (coef_queue.size() != 0 || busy) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		dir_now = d;
	endtask

	// feed 64 words; random idle bursts unless told otherwise
	task automatic load_block(input block_row_t row, input bit idle);
		int vy;
		int vcb;
		int vcr;
		for (int i = 0; i < Area; i++) begin
			vy = fill_value(row.fill, row.y, i);
			vcb = fill_value(row.fill, row.cb, i);
			vcr = fill_value(row.fill, row.cr, i);
			if (idle && $urandom_range(0, 7) == 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			start <= 1'b1;
			sample_y <= vy[SampleBits-1:0];
			sample_cb <= vcb[SampleBits-1:0];
			sample_cr <= vcr[SampleBits-1:0];
			do @(posedge clk); while (busy);
			loaded[0][i] = $signed(vy[SampleBits-1:0]);
			loaded[1][i] = $signed(vcb[SampleBits-1:0]);
			loaded[2][i] = $signed(vcr[SampleBits-1:0]);
		end
		start <= 1'b0;
		predict_block(row);
	endtask

	// results cannot be held off: take each one on the strobe
	always @(posedge clk) begin
		coef_word_t want;
		if (arst_n && done) begin
			if (coef_queue.size() == 0) begin
				report_mismatch("unexpected word out_y", out_y, 0);
			end else begin
				want = coef_queue.pop_front();
				if (out_y !== want.y) report_mismatch("out_y", out_y, want.y);
				if (out_cb !== want.cb) report_mismatch("out_cb", out_cb, want.cb);
				if (out_cr !== want.cr) report_mismatch("out_cr", out_cr, want.cr);
				if (block_last !== want.last)
					report_mismatch("block_last", block_last, want.last);
			end
		end
	end

	block_row_t directed [6];
	block_row_t row;
	int wait_cycles;

	initial begin
		// dc of a flat forward block is 8x the level, saturated
		directed[0] = '{DIR_FORWARD, FILL_CONST, 0, 0, 0, 1, 0, 0, 0};
		directed[1] = '{DIR_FORWARD, FILL_CONST, 2047, -2048, 1, 1, 2047, -2048, 8};
		directed[2] = '{DIR_FORWARD, FILL_CONST, -1, 100, -256, 1, -8, 800, -2048};
		directed[3] = '{DIR_FORWARD, FILL_CHECKER, 2047, -2048, 1000, 0, 0, 0, 0};
		directed[4] = '{DIR_INVERSE, FILL_IMPULSE, 2047, -2048, 5, 0, 0, 0, 0};
		directed[5] = '{DIR_INVERSE, FILL_CONST, 2047, -2048, -1, 0, 0, 0, 0};

		err_count = 0;
		cycle_count = 0;
		dir_now = DIR_FORWARD;
		start = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		sample_y = '0;
		sample_cb = '0;
		sample_cr = '0;
		for (int k = 0; k < Side; k++)
			for (int n = 0; n < Side; n++)
				cos_table[k][n] = round_away(
					longint'(int_sqrt((k == 0 ? 64'd1 << 60 : 64'd1 << 61) / Side))
					* angle_q30((2 * n + 1) * k), 60 - CosFracBits);

		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first block runs on the reset direction
		load_block(directed[0], 1'b1);
		for (int r = 1; r < 6; r++) begin
			write_direction(directed[r].dir);
			load_block(directed[r], 1'b1);
		end

		// random block, either direction, without idling
		row = '{$urandom_range(0, 1), ($urandom_range(0, 2) == 0) ? FILL_SMALL
			: FILL_RANDOM, 0, 0, 0, 0, 0, 0, 0};
		write_direction(row.dir);
		load_block(row, 1'b0);

		wait_cycles = 0;
		while (coef_queue.size() != 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (20) @(posedge clk);
		if (err_count == 0 && coef_queue.size() == 0) begin
			$display("dct_8x8_three_channel_tb: PASS");
		end else begin
			$display("dct_8x8_three_channel_tb: FAIL");
		end
		$finish;
	end

endmodule
